[src/metbl_pkg.sv]
// shared types and codes for the mesh edge table build and lookup block
`default_nettype none
package metbl_pkg;

  // operation codes
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_BUILD  = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic        is_quad;
    logic [15:0] vertex_a;
    logic [15:0] vertex_b;
    logic [15:0] vertex_c;
    logic [15:0] vertex_d;
    logic [9:0]  edge_slot;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  edge_index;
    logic [15:0] edge_low;
    logic [15:0] edge_high;
    logic [10:0] edge_count;
    logic [8:0]  face_count;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_LOAD,
    S_SORT_I, S_SORT_K, S_SORT_J, S_SORT_C,
    S_DD_RD, S_DD_C,
    S_SR_P, S_SR_C, S_RD_C, S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    RD_NONE, RD_RAW_I, RD_RAW_JM1, RD_UNIQ_MID, RD_UNIQ_SLOT
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_RAW_SIDE, WR_RAW_J_KEY, WR_RAW_J_Q, WR_UNIQ
  } wr_sel_t;

  typedef enum logic [2:0] {
    RES_NONE, RES_OK, RES_FULL, RES_FOUND, RES_MISS, RES_SLOT, RES_BAD
  } res_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     capture;
    rd_sel_t  rd;
    wr_sel_t  wr;
    logic     i_init1;
    logic     i_init0;
    logic     i_inc;
    logic     j_load;
    logic     j_dec;
    logic     key_from_q;
    logic     key_from_in;
    logic     u_init;
    logic     ucount_set;
    logic     lo_upd;
    logic     hi_upd;
    logic     face_inc;
    res_sel_t res;
    logic     out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       side_last;
    logic       i_done;
    logic       j_zero;
    logic       raw_gt;
    logic       keep;
    logic       srch_empty;
    logic       eq;
    logic       lt;
    logic       slot_ok;
    logic       out_busy;
  } sts_t;

endpackage
`default_nettype wire

[src/metbl_ctrl.sv]
// controller state machine sequencing load, sort, dedup, search and read
`default_nettype none
module metbl_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire metbl_pkg::sts_t sts,
  output metbl_pkg::cmd_t    cmd
);
  import metbl_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (sts.op)
          OP_LOAD:   state_next = sts.full ? S_FINISH : S_LOAD;
          OP_BUILD:  state_next = S_SORT_I;
          OP_LOOKUP: state_next = S_SR_P;
          default:   state_next = sts.slot_ok ? S_RD_C : S_FINISH;
        endcase
      end
      S_LOAD:   if (sts.side_last) state_next = S_FINISH;
      S_SORT_I: state_next = sts.i_done ? S_DD_RD : S_SORT_K;
      S_SORT_K: state_next = S_SORT_J;
      S_SORT_J: state_next = sts.j_zero ? S_SORT_I : S_SORT_C;
      S_SORT_C: state_next = sts.raw_gt ? S_SORT_J : S_SORT_I;
      S_DD_RD:  state_next = sts.i_done ? S_FINISH : S_DD_C;
      S_DD_C:   state_next = S_DD_RD;
      S_SR_P:   state_next = sts.srch_empty ? S_FINISH : S_SR_C;
      S_SR_C:   state_next = sts.eq ? S_FINISH : S_SR_P;
      S_RD_C:   state_next = S_FINISH;
      S_FINISH: if (!sts.out_busy) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    cmd.rd = RD_NONE;
    cmd.wr = WR_NONE;
    cmd.res = RES_NONE;
    in_ready = (state == S_IDLE);
    case (state)
      S_IDLE: cmd.capture = in_valid;
      S_DISPATCH: begin
        case (sts.op)
          OP_LOAD: if (sts.full) cmd.res = RES_FULL;
          OP_BUILD: cmd.i_init1 = 1'b1;
          OP_LOOKUP: cmd.key_from_in = 1'b1;
          default: begin
            if (sts.slot_ok) cmd.rd = RD_UNIQ_SLOT;
            else cmd.res = RES_BAD;
          end
        endcase
      end
      S_LOAD: begin
        cmd.wr = WR_RAW_SIDE;
        if (sts.side_last) begin
          cmd.face_inc = 1'b1;
          cmd.res = RES_OK;
        end
      end
      S_SORT_I: begin
        if (sts.i_done) begin
          cmd.i_init0 = 1'b1;
          cmd.u_init = 1'b1;
        end else begin
          cmd.rd = RD_RAW_I;
        end
      end
      S_SORT_K: begin
        cmd.key_from_q = 1'b1;
        cmd.j_load = 1'b1;
      end
      S_SORT_J: begin
        if (sts.j_zero) begin
          cmd.wr = WR_RAW_J_KEY;
          cmd.i_inc = 1'b1;
        end else begin
          cmd.rd = RD_RAW_JM1;
        end
      end
      S_SORT_C: begin
        if (sts.raw_gt) begin
          cmd.wr = WR_RAW_J_Q;
          cmd.j_dec = 1'b1;
        end else begin
          cmd.wr = WR_RAW_J_KEY;
          cmd.i_inc = 1'b1;
        end
      end
      S_DD_RD: begin
        if (sts.i_done) begin
          cmd.ucount_set = 1'b1;
          cmd.res = RES_OK;
        end else begin
          cmd.rd = RD_RAW_I;
        end
      end
      S_DD_C: begin
        if (sts.keep) cmd.wr = WR_UNIQ;
        cmd.i_inc = 1'b1;
      end
      S_SR_P: begin
        if (sts.srch_empty) cmd.res = RES_MISS;
        else cmd.rd = RD_UNIQ_MID;
      end
      S_SR_C: begin
        if (sts.eq) cmd.res = RES_FOUND;
        else if (sts.lt) cmd.lo_upd = 1'b1;
        else cmd.hi_upd = 1'b1;
      end
      S_RD_C: cmd.res = RES_SLOT;
      S_FINISH: cmd.out_load = !sts.out_busy;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[src/metbl_dp.sv]
// datapath: edge memories, counters, search bounds and result register
`default_nettype none
module metbl_dp #(
  parameter int MAX_FACES   = 256,
  parameter int MAX_EDGES   = 1024,
  parameter int VERTEX_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire metbl_pkg::in_item_t in_data,
  input  wire metbl_pkg::cmd_t     cmd,
  output metbl_pkg::sts_t          sts,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output metbl_pkg::out_item_t     out_data
);
  import metbl_pkg::*;

  localparam int VB = VERTEX_BITS;
  localparam int KW = 2 * VERTEX_BITS;
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int FW = $clog2(MAX_FACES + 1);
  localparam logic [CW:0] MAXE_EXT = (CW + 1)'(MAX_EDGES);
  localparam logic [FW-1:0] MAXF = FW'(MAX_FACES);

  // ordered edge key, low vertex in the upper half
  function automatic logic [KW-1:0] make_key(input logic [VB-1:0] p, input logic [VB-1:0] q);
    logic [KW-1:0] k;
    if (q < p) k = {q, p};
    else k = {p, q};
    return k;
  endfunction

  logic [KW-1:0] raw_mem  [MAX_EDGES];
  logic [KW-1:0] uniq_mem [MAX_EDGES];
  logic [KW-1:0] raw_q, uniq_q;

  in_item_t      in_q;
  logic [CW-1:0] raw_count, ucount, i, j, u, lo, hi, mid;
  logic [FW-1:0] faces;
  logic [1:0]    side;
  logic [KW-1:0] key, last;
  logic [1:0]    res_status;
  logic [9:0]    res_idx;
  logic [KW-1:0] res_key;

  logic [VB-1:0] vtx [4];
  logic [1:0]    side_nx;
  logic [CW:0]   lohi;
  logic [CW-1:0] mid_c, jm1;
  logic [2:0]    sides;

  assign vtx[0] = VB'(in_q.vertex_a);
  assign vtx[1] = VB'(in_q.vertex_b);
  assign vtx[2] = VB'(in_q.vertex_c);
  assign vtx[3] = VB'(in_q.vertex_d);
  assign sides  = in_q.is_quad ? 3'd4 : 3'd3;
  assign side_nx = sts.side_last ? 2'd0 : side + 2'd1;
  assign lohi   = {1'b0, lo} + {1'b0, hi};
  assign mid_c  = lohi[CW:1];
  assign jm1    = j - CW'(1);

  // status toward the controller
  always_comb begin
    sts.op         = in_q.operation;
    sts.full       = (faces >= MAXF) || ({1'b0, raw_count} + (CW + 1)'(sides) > MAXE_EXT);
    sts.side_last  = ({1'b0, side} == sides - 3'd1);
    sts.i_done     = (i >= raw_count);
    sts.j_zero     = (j == '0);
    sts.raw_gt     = (raw_q > key);
    sts.keep       = (u == '0) || (last != raw_q);
    sts.srch_empty = (lo >= hi);
    sts.eq         = (uniq_q == key);
    sts.lt         = (uniq_q < key);
    sts.slot_ok    = (32'(in_q.edge_slot) < 32'(ucount));
    sts.out_busy   = out_valid && !out_ready;
  end

  // raw edge memory
  always_ff @(posedge clk) begin
    case (cmd.wr)
      WR_RAW_SIDE:  raw_mem[raw_count[AW-1:0]] <= make_key(vtx[side], vtx[side_nx]);
      WR_RAW_J_KEY: raw_mem[j[AW-1:0]] <= key;
      WR_RAW_J_Q:   raw_mem[j[AW-1:0]] <= raw_q;
      default: ;
    endcase
    if (cmd.rd == RD_RAW_I) raw_q <= raw_mem[i[AW-1:0]];
    else if (cmd.rd == RD_RAW_JM1) raw_q <= raw_mem[jm1[AW-1:0]];
  end

  // unique edge memory
  always_ff @(posedge clk) begin
    if (cmd.wr == WR_UNIQ) uniq_mem[u[AW-1:0]] <= raw_q;
    if (cmd.rd == RD_UNIQ_MID) uniq_q <= uniq_mem[mid_c[AW-1:0]];
    else if (cmd.rd == RD_UNIQ_SLOT) uniq_q <= uniq_mem[AW'(in_q.edge_slot)];
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_q <= in_data;
      side <= 2'd0;
    end
    if (cmd.wr == WR_RAW_SIDE) side <= side + 2'd1;
    if (cmd.i_init1) i <= CW'(1);
    else if (cmd.i_init0) i <= '0;
    else if (cmd.i_inc) i <= i + CW'(1);
    if (cmd.j_load) j <= i;
    else if (cmd.j_dec) j <= jm1;
    if (cmd.key_from_q) key <= raw_q;
    else if (cmd.key_from_in) key <= make_key(vtx[0], vtx[1]);
    if (cmd.u_init) u <= '0;
    else if (cmd.wr == WR_UNIQ) u <= u + CW'(1);
    if (cmd.wr == WR_UNIQ) last <= raw_q;
    if (cmd.key_from_in) begin
      lo <= '0;
      hi <= ucount;
    end else if (cmd.lo_upd) begin
      lo <= mid + CW'(1);
    end else if (cmd.hi_upd) begin
      hi <= mid;
    end
    if (cmd.rd == RD_UNIQ_MID) mid <= mid_c;
  end

  // persistent counters
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_count <= '0;
      ucount    <= '0;
      faces     <= '0;
    end else begin
      if (cmd.wr == WR_RAW_SIDE) raw_count <= raw_count + CW'(1);
      if (cmd.ucount_set) ucount <= u;
      if (cmd.face_inc) faces <= faces + FW'(1);
    end
  end

  // staged result fields
  always_ff @(posedge clk) begin
    case (cmd.res)
      RES_OK:    begin res_status <= ST_OK;   res_idx <= '0; res_key <= '0; end
      RES_FULL:  begin res_status <= ST_FULL; res_idx <= '0; res_key <= '0; end
      RES_FOUND: begin res_status <= ST_OK;   res_idx <= 10'(mid); res_key <= key; end
      RES_MISS:  begin res_status <= ST_MISS; res_idx <= '0; res_key <= key; end
      RES_SLOT:  begin res_status <= ST_OK;   res_idx <= in_q.edge_slot; res_key <= uniq_q; end
      RES_BAD:   begin res_status <= ST_MISS; res_idx <= '0; res_key <= '0; end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.status     <= res_status;
      out_data.edge_index <= res_idx;
      out_data.edge_low   <= 16'(res_key[KW-1:VB]);
      out_data.edge_high  <= 16'(res_key[VB-1:0]);
      out_data.edge_count <= 11'(ucount);
      out_data.face_count <= 9'(faces);
    end
  end

endmodule
`default_nettype wire

[src/mesh_edge_table_build_lookup_core.sv]
// top level of the mesh edge table build and lookup block
// load: one raw memory write per face side; a load into a full store is refused
// build: insertion sort of the raw edges, then a duplicate pass into the unique store;
// lookup: binary search of the unique store; read: returns the edge in a slot, or a
// miss when the slot is out of range; one transaction in flight
// reset is synchronous; counts clear, edge memories stay unwritten and are never read stale
`default_nettype none
module mesh_edge_table_build_lookup_core #(
  parameter int MAX_FACES   = 256,
  parameter int MAX_EDGES   = 1024,
  parameter int VERTEX_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire metbl_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output metbl_pkg::out_item_t      out_data
);
  import metbl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller
  metbl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  metbl_dp #(
    .MAX_FACES   (MAX_FACES),
    .MAX_EDGES   (MAX_EDGES),
    .VERTEX_BITS (VERTEX_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // one transaction at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while busy");

  // result loads only when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.out_load)
    else $error("result overwritten");

  // full refusal carries no edge
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == ST_FULL) |-> (out_data.edge_index == '0))
    else $error("full status with edge index");

endmodule
`default_nettype wire
